@@ hdl/c2u_pkg.sv @@
// Shared types, constants and the Windows-1252 upper-control table for the
// CP-1252 to UTF-8 transcoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c2u_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CpW     = 16;
	localparam int unsigned MaxOut  = 3;
	localparam int unsigned IdxW    = 2;

	localparam logic [CpW-1:0]   CpOneByteLim = 16'h0080;
	localparam logic [CpW-1:0]   CpTwoByteLim = 16'h0800;
	localparam logic [ByteW-1:0] LeadTwo      = 8'hC0;
	localparam logic [ByteW-1:0] LeadThree    = 8'hE0;
	localparam logic [ByteW-1:0] ContMark     = 8'h80;
	localparam logic [ByteW-1:0] EndMarker    = 8'h00;

	// Encoded form of one input byte: up to three UTF-8 bytes, index of the last one
	typedef struct packed {
		logic [MaxOut-1:0][ByteW-1:0] bytes;
		logic [IdxW-1:0]              last_idx;
		logic                         eos;
	} enc_t;

	// Code points for bytes 0x80..0x9F; undefined codes map to themselves
	function automatic logic [CpW-1:0] win1252_hi(input logic [4:0] lo);
		logic [CpW-1:0] cp;
		begin
			case (lo)
				5'h00: cp = 16'h20AC;  5'h01: cp = 16'h0081;
				5'h02: cp = 16'h201A;  5'h03: cp = 16'h0192;
				5'h04: cp = 16'h201E;  5'h05: cp = 16'h2026;
				5'h06: cp = 16'h2020;  5'h07: cp = 16'h2021;
				5'h08: cp = 16'h02C6;  5'h09: cp = 16'h2030;
				5'h0A: cp = 16'h0160;  5'h0B: cp = 16'h2039;
				5'h0C: cp = 16'h0152;  5'h0D: cp = 16'h008D;
				5'h0E: cp = 16'h017D;  5'h0F: cp = 16'h008F;
				5'h10: cp = 16'h0090;  5'h11: cp = 16'h2018;
				5'h12: cp = 16'h2019;  5'h13: cp = 16'h201C;
				5'h14: cp = 16'h201D;  5'h15: cp = 16'h2022;
				5'h16: cp = 16'h2013;  5'h17: cp = 16'h2014;
				5'h18: cp = 16'h02DC;  5'h19: cp = 16'h2122;
				5'h1A: cp = 16'h0161;  5'h1B: cp = 16'h203A;
				5'h1C: cp = 16'h0153;  5'h1D: cp = 16'h009D;
				5'h1E: cp = 16'h017E;  default: cp = 16'h0178;
			endcase
			return cp;
		end
	endfunction

endpackage

`default_nettype wire

@@ hdl/c2u_encode.sv @@
// Maps one CP-1252 byte to its UTF-8 byte sequence (or the end marker).
// Depends on c2u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2u_encode
	import c2u_pkg::*;
(
	input  wire logic [ByteW-1:0] in_byte,
	output enc_t                  enc
);

	logic [CpW-1:0] cp;

	always_comb begin
		if (in_byte[7:5] == 3'b100) begin
			cp = win1252_hi(in_byte[4:0]);
		end else begin
			cp = {{(CpW-ByteW){1'b0}}, in_byte};
		end
	end

	always_comb begin
		enc = '0;
		if (in_byte == EndMarker) begin
			enc.bytes[0] = EndMarker;
			enc.last_idx = 2'd0;
			enc.eos      = 1'b1;
		end else if (cp < CpOneByteLim) begin
			enc.bytes[0] = cp[7:0];
			enc.last_idx = 2'd0;
		end else if (cp < CpTwoByteLim) begin
			enc.bytes[0] = LeadTwo | {3'b000, cp[10:6]};
			enc.bytes[1] = ContMark | {2'b00, cp[5:0]};
			enc.last_idx = 2'd1;
		end else begin
			enc.bytes[0] = LeadThree | {4'b0000, cp[15:12]};
			enc.bytes[1] = ContMark | {2'b00, cp[11:6]};
			enc.bytes[2] = ContMark | {2'b00, cp[5:0]};
			enc.last_idx = 2'd2;
		end
	end

endmodule

`default_nettype wire

@@ hdl/cp1252_string_to_utf8.sv @@
// Top level of the CP-1252 to UTF-8 transcoder for padded string streams.
// Depends on c2u_pkg and c2u_encode.
// An accepted input word is registered in stage 1; its UTF-8 words then pass
// one at a time through the output register. One output word per cycle
// while out_stall allows; an input word yields 1, 2 or 3 output words, set by
// its UTF-8 length; the next input word is taken as its last word leaves.
// Pad words are taken without occupying the output side.
// Reset (arst_n low, asynchronous) empties both stages and arms pad detection.
`timescale 1ns / 1ps
`default_nettype none

module cp1252_string_to_utf8
	import c2u_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [ByteW-1:0] in_byte,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [ByteW-1:0]      utf8_byte,
	output logic                  last_of_char,
	output logic                  end_of_string
);

	enc_t            enc;
	enc_t            enc_s1;
	logic            s1_valid_s1;
	logic [IdxW-1:0] idx_q;
	logic            awaiting_pad_q;
	logic            out_valid_q;
	logic [ByteW-1:0] utf8_byte_q;
	logic            last_q;
	logic            eos_q;

	logic in_acc;
	logic load_out;
	logic last_pick;

	c2u_encode u_encode (
		.in_byte (in_byte),
		.enc     (enc)
	);

	// The output register takes a word whenever it is empty or being drained
	assign load_out  = s1_valid_s1 && (!out_valid_q || !out_stall);
	// Final word of the held sequence leaves stage 1 this cycle
	assign last_pick = load_out && (idx_q == enc_s1.last_idx);
	// Hold off the source only while stage 1 is occupied and not emptying
	assign in_stall  = s1_valid_s1 && !last_pick;
	assign in_acc    = in_valid && !in_stall;

	// Stage 1: hold the encoded sequence; drop pad words here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1    <= 1'b0;
			awaiting_pad_q <= 1'b1;
			idx_q          <= '0;
		end else begin
			// A new sequence refills stage 1 in the cycle the old one leaves
			if (in_acc && !awaiting_pad_q) begin
				s1_valid_s1 <= 1'b1;
			end else if (last_pick) begin
				s1_valid_s1 <= 1'b0;
			end
			if (in_acc) begin
				if (awaiting_pad_q) begin
					awaiting_pad_q <= 1'b0;
				end else if (in_byte == EndMarker) begin
					awaiting_pad_q <= 1'b1;
				end
			end
			// Advance through the sequence one word per output load
			if (last_pick) begin
				idx_q <= '0;
			end else if (load_out) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !awaiting_pad_q) begin
			enc_s1 <= enc;
		end
	end

	// Output register: parts the output handshake from stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			utf8_byte_q <= enc_s1.bytes[idx_q];
			last_q      <= (idx_q == enc_s1.last_idx);
			eos_q       <= enc_s1.eos;
		end
	end

	assign out_valid     = out_valid_q;
	assign utf8_byte     = utf8_byte_q;
	assign last_of_char  = last_q;
	assign end_of_string = eos_q;

	// Sequence index never runs past the held sequence
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> (idx_q <= enc_s1.last_idx))
		else $error("sequence index beyond last word");

	// Index rests at zero while stage 1 is empty
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> (idx_q == '0))
		else $error("sequence index not cleared");

	// Every non-pad word taken lands in stage 1
	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !awaiting_pad_q) |=> s1_valid_s1)
		else $error("accepted word lost");

	// End marker is a single zero word closing its character
	a_eos_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eos_q) |-> (utf8_byte_q == EndMarker && last_q))
		else $error("malformed end marker");

endmodule

`default_nettype wire

@@ tb/cp1252_string_to_utf8_tb.sv @@
// Self-checking testbench for cp1252_string_to_utf8: directed and random padded
// CP-1252 string streams, checked word by word against a transcoder model.
// Depends on c2u_pkg and the cp1252_string_to_utf8 RTL.
`timescale 1ns / 1ps

module cp1252_string_to_utf8_tb;
	import c2u_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandWords  = 330;

	// Code points for the upper control range 0x80..0x9F of Windows-1252
	localparam logic [CpW-1:0] HI_CP [0:31] = '{
		16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
		16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
	};

	typedef struct {
		logic [ByteW-1:0] value;
		bit               drain;  // hold this word back until all output has arrived
	} cp_word_t;

	typedef struct {
		logic [ByteW-1:0] value;
		logic             is_last;
		logic             eos;
	} utf8_word_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             in_valid      = 1'b0;
	logic             in_stall;
	logic [ByteW-1:0] in_byte       = '0;
	logic             out_valid;
	logic             out_stall     = 1'b0;
	logic [ByteW-1:0] utf8_byte;
	logic             last_of_char;
	logic             end_of_string;

	cp_word_t   cp_pending [$];  // words still to be offered to the block
	utf8_word_t utf8_due   [$];  // UTF-8 words the block owes, oldest first

	bit          pad_pending = 1'b1;  // model state: next word is a pad
	int unsigned words_taken = 0;
	int unsigned err_count   = 0;
	int unsigned cycle_count = 0;
	bit          quiet;               // stretch with no idling on either side

	cp1252_string_to_utf8 uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.utf8_byte    (utf8_byte),
		.last_of_char (last_of_char),
		.end_of_string(end_of_string)
	);

	always #10 clk = ~clk;

	assign quiet = (words_taken >= 120) && (words_taken < 200);

	task automatic owe_word(input logic [ByteW-1:0] value, input logic is_last,
			input logic eos);
		utf8_word_t w;
		begin
			w.value   = value;
			w.is_last = is_last;
			w.eos     = eos;
			utf8_due  = {utf8_due, w};
		end
	endtask

	// Advance the transcoder model by one accepted word and queue what it owes
	task automatic transcode_word(input logic [ByteW-1:0] b);
		logic [CpW-1:0] cp;
		begin
			if (pad_pending) begin
				// drop the pad, whatever its value, zero included
				pad_pending = 1'b0;
			end else if (b == EndMarker) begin
				// terminator: one end marker, then re-arm for the next pad
				pad_pending = 1'b1;
				owe_word(EndMarker, 1'b1, 1'b1);
			end else begin
				if (b >= 8'h80 && b < 8'hA0)
					cp = HI_CP[b[4:0]];
				else
					cp = {8'h00, b};
				if (cp < CpOneByteLim) begin
					owe_word(cp[7:0], 1'b1, 1'b0);
				end else if (cp < CpTwoByteLim) begin
					owe_word(LeadTwo | {3'b000, cp[10:6]}, 1'b0, 1'b0);
					owe_word(ContMark | {2'b00, cp[5:0]}, 1'b1, 1'b0);
				end else begin
					owe_word(LeadThree | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
					owe_word(ContMark | {2'b00, cp[11:6]}, 1'b0, 1'b0);
					owe_word(ContMark | {2'b00, cp[5:0]}, 1'b1, 1'b0);
				end
			end
		end
	endtask

	task automatic add_word(input logic [ByteW-1:0] value, input bit drain);
		cp_word_t w;
		begin
			w.value    = value;
			w.drain    = drain;
			cp_pending = {cp_pending, w};
		end
	endtask

	function automatic logic [ByteW-1:0] pick_char();
		case ($urandom_range(2))
			0:       return 8'($urandom_range(127, 1));
			1:       return 8'($urandom_range(159, 128));
			default: return 8'($urandom_range(255, 160));
		endcase
	endfunction

	// Driver: offer pending words, hold a stalled word, idle at random
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				transcode_word(in_byte);
				words_taken++;
			end
			// only touch the payload once the current word has gone or none is up
			if (!in_valid || !in_stall) begin
				if (cp_pending.size() != 0
						&& !(cp_pending[0].drain && utf8_due.size() != 0)
						&& (quiet || $urandom_range(99) >= 15)) begin
					in_valid <= 1'b1;
					in_byte  <= cp_pending[0].value;
					void'(cp_pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random and check every accepted word against the oldest due one
	always @(posedge clk) begin
		utf8_word_t w;
		if (arst_n) begin
			out_stall <= !quiet && ($urandom_range(99) < 15);
			if (out_valid && !out_stall) begin
				if (utf8_due.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %02h last %b eos %b",
						$time, utf8_byte, last_of_char, end_of_string);
					err_count++;
				end else begin
					w = utf8_due.pop_front();
					if (utf8_byte !== w.value) begin
						$display("%0t: utf8_byte mismatch: expected %02h, actual %02h",
							$time, w.value, utf8_byte);
						err_count++;
					end
					if (last_of_char !== w.is_last) begin
						$display("%0t: last_of_char mismatch: expected %b, actual %b",
							$time, w.is_last, last_of_char);
						err_count++;
					end
					if (end_of_string !== w.eos) begin
						$display("%0t: end_of_string mismatch: expected %b, actual %b",
							$time, w.eos, end_of_string);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog: end the run as failed once cycle_count reaches CycleLimit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("cp1252_string_to_utf8 verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned n_chars;
		int unsigned n_strings;

		// Directed: zero pad with an empty string
		add_word(8'h00, 1'b0);
		add_word(8'h00, 1'b0);
		// Range extremes, undefined table codes and a three-byte table entry
		add_word(8'hFF, 1'b0);
		add_word(8'h01, 1'b0);
		add_word(8'h7F, 1'b0);
		add_word(8'h80, 1'b0);
		add_word(8'h81, 1'b0);
		add_word(8'h8D, 1'b0);
		add_word(8'h99, 1'b0);
		add_word(8'h9F, 1'b0);
		add_word(8'hA0, 1'b0);
		add_word(8'hFF, 1'b0);
		add_word(8'h00, 1'b0);
		// Pad from the table range, held back until the block has drained,
		// then an ASCII character
		add_word(8'h80, 1'b1);
		add_word(8'h41, 1'b0);
		add_word(8'h00, 1'b0);

		// Random: mostly well-formed strings, some raw noise
		n_strings = 0;
		while (cp_pending.size() < RandWords + 16) begin
			if ($urandom_range(9) == 0) begin
				n_chars = $urandom_range(8, 1);
				repeat (n_chars) add_word(8'($urandom_range(255)), 1'b0);
			end else begin
				// hold one pad back until the block has fully drained
				add_word(8'($urandom_range(255)), n_strings == 10);
				n_chars = $urandom_range(12);
				repeat (n_chars) add_word(pick_char(), 1'b0);
				add_word(EndMarker, 1'b0);
			end
			n_strings++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the stimulus to go and every due word to arrive, then settle
		while (cp_pending.size() != 0 || in_valid || utf8_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0 && utf8_due.size() == 0) begin
			$display("cp1252_string_to_utf8 verification clean");
		end else begin
			$display("cp1252_string_to_utf8 verification failed");
		end
		$finish;
	end

endmodule
